FILE: design/kcp_pkg.sv
package kcp_pkg;

   localparam int KEY_LEN = 17;
   localparam int MAX_FRAC_DIGITS = 6;
   localparam int MANT_W = 40;
   localparam int KEY_W = 8 * KEY_LEN;
   localparam int NUM_W = MANT_W + 17;
   localparam int DIV_W = 24;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);

   localparam logic [MANT_W-1:0] MANT_MAX = {MANT_W{1'b1}};

   localparam logic [7:0] CH_A = 8'h41;
   localparam logic [7:0] CH_G = 8'h47;
   localparam logic [7:0] CH_Q = 8'h51;
   localparam logic [7:0] CH_Z = 8'h5A;
   localparam logic [7:0] CH_0 = 8'h30;
   localparam logic [7:0] CH_9 = 8'h39;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_POINT = 8'h2E;

   localparam logic [1:0] ADDR_KEY_LOW = 2'd0;
   localparam logic [1:0] ADDR_KEY_MID = 2'd1;
   localparam logic [1:0] ADDR_KEY_LAST = 2'd2;
   localparam logic [1:0] ADDR_SCALE = 2'd3;

   localparam logic [15:0] SCALE_RESET = 16'd256;

   typedef enum logic [1:0] {
      ACT_WRITE = 2'd0,
      ACT_STOP  = 2'd1,
      ACT_START = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_KEY  = 2'd1,
      PH_BODY = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      BK_IDLE = 3'd0,
      BK_DIV  = 3'd1,
      BK_MUL  = 3'd2,
      BK_SAT  = 3'd3,
      BK_LOOP = 3'd4
   } back_state_type;

   // one queued job: an optional parameter write followed by an optional loop action
   typedef struct packed {
      logic              has_write;
      logic [2:0]        target;
      logic [MANT_W-1:0] mantissa;
      logic [2:0]        frac_digits;
      logic              negative;
      logic              has_loop;
      action_type        loop_action;
   } job_type;

   function automatic logic [DIV_W-1:0] pow10(input logic [2:0] n);
      logic [DIV_W-1:0] p;
      begin
         case (n)
            3'd0: p = 24'd1;
            3'd1: p = 24'd10;
            3'd2: p = 24'd100;
            3'd3: p = 24'd1000;
            3'd4: p = 24'd10000;
            3'd5: p = 24'd100000;
            3'd6: p = 24'd1000000;
            default: p = 24'd10000000;
         endcase
         return p;
      end
   endfunction

endpackage

FILE: design/kcp_front.sv
module kcp_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [7:0]               req_tdata,
   input  logic [1:0]               req_tuser,
   input  logic [kcp_pkg::KEY_W-1:0] key_vec,
   input  logic                     queue_full,
   output logic                     push,
   output kcp_pkg::job_type         push_job
);

   kcp_pkg::phase_type phase_ff, phase_in;
   logic [4:0] byte_count_ff, byte_count_in;
   logic key_match_ff, key_match_in;
   logic [2:0] pending_target_ff, pending_target_in;
   logic value_active_ff, value_active_in;
   logic [kcp_pkg::MANT_W-1:0] mantissa_ff, mantissa_in;
   logic [2:0] frac_digits_ff, frac_digits_in;
   logic frac_seen_ff, frac_seen_in;
   logic negative_ff, negative_in;
   logic stop_requested_ff, stop_requested_in;

   logic accept;
   logic [7:0] rx_byte;
   logic som;
   logic running;
   logic [7:0] key_byte;
   logic [kcp_pkg::MANT_W+3:0] times10;
   logic is_digit;

   assign rx_byte = req_tdata;
   assign som = req_tuser[0];
   assign running = req_tuser[1];
   assign req_tready = !queue_full;
   assign accept = req_tvalid && req_tready;
   assign is_digit = (rx_byte >= kcp_pkg::CH_0) && (rx_byte <= kcp_pkg::CH_9);

   always_comb begin
      phase_in = phase_ff;
      byte_count_in = byte_count_ff;
      key_match_in = key_match_ff;
      pending_target_in = pending_target_ff;
      value_active_in = value_active_ff;
      mantissa_in = mantissa_ff;
      frac_digits_in = frac_digits_ff;
      frac_seen_in = frac_seen_ff;
      negative_in = negative_ff;
      stop_requested_in = stop_requested_ff;
      push_job = '0;
      push_job.loop_action = kcp_pkg::ACT_WRITE;
      key_byte = 8'd0;
      times10 = '0;

      // new message start drops everything open
      if (som) begin
         phase_in = kcp_pkg::PH_KEY;
         byte_count_in = 5'd0;
         key_match_in = 1'b1;
         pending_target_in = 3'd0;
         value_active_in = 1'b0;
         mantissa_in = '0;
         frac_digits_in = 3'd0;
         frac_seen_in = 1'b0;
         negative_in = 1'b0;
         stop_requested_in = 1'b0;
      end

      if (byte_count_in < 5'(kcp_pkg::KEY_LEN)) begin
         key_byte = key_vec[{byte_count_in, 3'b000} +: 8];
      end

      if (phase_in == kcp_pkg::PH_KEY) begin
         if (rx_byte != key_byte) begin
            key_match_in = 1'b0;
         end
         byte_count_in = byte_count_in + 5'd1;
         if (byte_count_in >= 5'(kcp_pkg::KEY_LEN)) begin
            phase_in = key_match_in ? kcp_pkg::PH_BODY : kcp_pkg::PH_IDLE;
         end
      end else if (phase_in == kcp_pkg::PH_BODY) begin
         if (value_active_in && is_digit) begin
            if (!frac_seen_in || frac_digits_in < 3'(kcp_pkg::MAX_FRAC_DIGITS)) begin
               times10 = ({4'd0, mantissa_in} << 3) + ({4'd0, mantissa_in} << 1)
                  + {36'd0, rx_byte - kcp_pkg::CH_0};
               if (times10 > {4'd0, kcp_pkg::MANT_MAX}) begin
                  mantissa_in = kcp_pkg::MANT_MAX;
               end else begin
                  mantissa_in = times10[kcp_pkg::MANT_W-1:0];
               end
               if (frac_seen_in) begin
                  frac_digits_in = frac_digits_in + 3'd1;
               end
            end
         end else if (value_active_in && rx_byte == kcp_pkg::CH_MINUS) begin
            negative_in = 1'b1;
         end else if (value_active_in && rx_byte == kcp_pkg::CH_POINT) begin
            frac_seen_in = 1'b1;
         end else begin
            // value closes on any other byte
            if (value_active_in) begin
               push_job.has_write = 1'b1;
               push_job.target = pending_target_in;
               push_job.mantissa = mantissa_in;
               push_job.frac_digits = frac_digits_in;
               push_job.negative = negative_in;
               value_active_in = 1'b0;
               mantissa_in = '0;
               frac_digits_in = 3'd0;
               frac_seen_in = 1'b0;
               negative_in = 1'b0;
            end
            if (rx_byte >= kcp_pkg::CH_A && rx_byte <= kcp_pkg::CH_G) begin
               pending_target_in = 3'(rx_byte - kcp_pkg::CH_A);
               value_active_in = 1'b1;
            end else if (rx_byte == kcp_pkg::CH_Q) begin
               stop_requested_in = 1'b1;
            end else if (rx_byte == kcp_pkg::CH_Z) begin
               if (stop_requested_in) begin
                  push_job.has_loop = 1'b1;
                  push_job.loop_action = kcp_pkg::ACT_STOP;
               end else if (!running) begin
                  push_job.has_loop = 1'b1;
                  push_job.loop_action = kcp_pkg::ACT_START;
               end
               phase_in = kcp_pkg::PH_IDLE;
            end
         end
      end

      push = accept && (push_job.has_write || push_job.has_loop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= kcp_pkg::PH_IDLE;
         byte_count_ff <= 5'd0;
         key_match_ff <= 1'b1;
         pending_target_ff <= 3'd0;
         value_active_ff <= 1'b0;
         mantissa_ff <= '0;
         frac_digits_ff <= 3'd0;
         frac_seen_ff <= 1'b0;
         negative_ff <= 1'b0;
         stop_requested_ff <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         byte_count_ff <= byte_count_in;
         key_match_ff <= key_match_in;
         pending_target_ff <= pending_target_in;
         value_active_ff <= value_active_in;
         mantissa_ff <= mantissa_in;
         frac_digits_ff <= frac_digits_in;
         frac_seen_ff <= frac_seen_in;
         negative_ff <= negative_in;
         stop_requested_ff <= stop_requested_in;
      end
   end

endmodule

FILE: design/kcp_queue.sv
module kcp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  kcp_pkg::job_type push_job,
   input  logic             pop,
   output logic             full,
   output logic             not_empty,
   output kcp_pkg::job_type head_job
);

   kcp_pkg::job_type slot_ff [kcp_pkg::QUEUE_DEPTH];
   logic [kcp_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [kcp_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [kcp_pkg::QPTR_W:0] count_ff, count_in;

   assign full = (count_ff == (kcp_pkg::QPTR_W + 1)'(kcp_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_job = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

FILE: design/kcp_back.sv
module kcp_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             not_empty,
   input  kcp_pkg::job_type head_job,
   output logic             pop,
   input  logic [15:0]      scale,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [31:0]      rsp_tdata,
   output logic [4:0]       rsp_tuser,
   output logic             rsp_tlast
);

   localparam int CNT_W = $clog2(kcp_pkg::NUM_W);
   localparam int CLAMP_W = kcp_pkg::MANT_W + 1;
   localparam int PROD_W = CLAMP_W + 16;

   kcp_pkg::back_state_type state_ff, state_in;
   kcp_pkg::job_type job_ff, job_in;
   logic [kcp_pkg::NUM_W-1:0] num_ff, num_in;
   logic [kcp_pkg::DIV_W-1:0] rem_ff, rem_in;
   logic [kcp_pkg::DIV_W-1:0] div_ff, div_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [PROD_W-1:0] prod_ff, prod_in;

   logic out_valid_ff, out_valid_in;
   kcp_pkg::action_type out_action_ff, out_action_in;
   logic [2:0] out_target_ff, out_target_in;
   logic [31:0] out_value_ff, out_value_in;
   logic out_last_ff, out_last_in;

   logic out_free;
   logic [kcp_pkg::DIV_W:0] trial;
   logic [kcp_pkg::DIV_W-1:0] head_p10;
   logic [CLAMP_W-1:0] clamped;
   logic [PROD_W-1:0] rounded;
   logic [PROD_W-1:0] mag;
   logic [PROD_W-1:0] limit;
   logic [31:0] mag32;

   assign out_free = !out_valid_ff || rsp_tready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = out_value_ff;
   assign rsp_tuser = {out_target_ff, out_action_ff};
   assign rsp_tlast = out_last_ff;

   assign trial = {rem_ff, num_ff[kcp_pkg::NUM_W-1]};
   assign head_p10 = kcp_pkg::pow10(head_job.frac_digits);

   always_comb begin
      state_in = state_ff;
      job_in = job_ff;
      num_in = num_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      cnt_in = cnt_ff;
      prod_in = prod_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_action_in = out_action_ff;
      out_target_in = out_target_ff;
      out_value_in = out_value_ff;
      out_last_in = out_last_ff;
      pop = 1'b0;
      clamped = '0;
      rounded = '0;
      mag = '0;
      limit = '0;
      mag32 = '0;

      case (state_ff)
         kcp_pkg::BK_IDLE: begin
            if (not_empty) begin
               pop = 1'b1;
               job_in = head_job;
               // numerator with round-half-up offset
               num_in = {1'b0, head_job.mantissa, 16'd0}
                  + {{(kcp_pkg::NUM_W - kcp_pkg::DIV_W){1'b0}}, head_p10 >> 1};
               rem_in = '0;
               div_in = head_p10;
               cnt_in = CNT_W'(kcp_pkg::NUM_W - 1);
               if (!head_job.has_write) begin
                  state_in = kcp_pkg::BK_LOOP;
               end else if (head_job.frac_digits == 3'd0) begin
                  state_in = kcp_pkg::BK_MUL;
               end else begin
                  state_in = kcp_pkg::BK_DIV;
               end
            end
         end
         kcp_pkg::BK_DIV: begin
            // restoring divide, one quotient bit a cycle
            if (trial >= {1'b0, div_ff}) begin
               rem_in = kcp_pkg::DIV_W'(trial - {1'b0, div_ff});
               num_in = {num_ff[kcp_pkg::NUM_W-2:0], 1'b1};
            end else begin
               rem_in = trial[kcp_pkg::DIV_W-1:0];
               num_in = {num_ff[kcp_pkg::NUM_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = kcp_pkg::BK_MUL;
            end
         end
         kcp_pkg::BK_MUL: begin
            if (num_ff > kcp_pkg::NUM_W'(1) << kcp_pkg::MANT_W) begin
               clamped = CLAMP_W'(1) << kcp_pkg::MANT_W;
            end else begin
               clamped = num_ff[CLAMP_W-1:0];
            end
            prod_in = {{(PROD_W - CLAMP_W){1'b0}}, clamped} * {{(PROD_W - 16){1'b0}}, scale};
            state_in = kcp_pkg::BK_SAT;
         end
         kcp_pkg::BK_SAT: begin
            rounded = (prod_ff + PROD_W'(128)) >> 8;
            if (job_ff.target == 3'd0) begin
               mag = rounded;
            end else begin
               mag = num_ff;
            end
            limit = job_ff.negative ? PROD_W'(33'h080000000) : PROD_W'(33'h07FFFFFFF);
            if (mag > limit) begin
               mag = limit;
            end
            mag32 = mag[31:0];
            if (out_free) begin
               out_valid_in = 1'b1;
               out_action_in = kcp_pkg::ACT_WRITE;
               out_target_in = job_ff.target;
               out_value_in = job_ff.negative ? (32'd0 - mag32) : mag32;
               out_last_in = !job_ff.has_loop;
               state_in = job_ff.has_loop ? kcp_pkg::BK_LOOP : kcp_pkg::BK_IDLE;
            end
         end
         kcp_pkg::BK_LOOP: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_action_in = job_ff.loop_action;
               out_target_in = 3'd0;
               out_value_in = 32'd0;
               out_last_in = 1'b1;
               state_in = kcp_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = kcp_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kcp_pkg::BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      cnt_ff <= cnt_in;
      prod_ff <= prod_in;
      out_action_ff <= out_action_in;
      out_target_ff <= out_target_in;
      out_value_ff <= out_value_in;
      out_last_ff <= out_last_in;
   end

endmodule

FILE: design/keyed_tagged_command_parser_top.sv
// channel    direction  payload
// req_*      in         tdata: rx_byte; tuser: start_of_message, loop_running
// rsp_*      out        tdata: value (Q16.16); tuser: action, target; tlast: last
// csr_*      in/out     apb, 64-bit data, registers at 8-byte steps
//
// front parser takes one byte a cycle while the job queue (4 entries) has room
// a byte that closes a value sends the back end through multiply and saturate, with
// the 57-step restoring divider first when it has a fraction; a loop action follows
// a write as a further result, or goes through the loop state on its own
// back end and front stall independently; results sit in an output register
// reset clears parser state, queue, back end and output valid; scale returns to 1.0
module keyed_tagged_command_parser_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] rx_byte
   input  logic [1:0]  req_tuser,    // [0] start_of_message, [1] loop_running
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,    // [31:0] value
   output logic [4:0]  rsp_tuser,    // [1:0] action, [4:2] target
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);

   logic [63:0] key_low_ff;
   logic [63:0] key_mid_ff;
   logic [7:0]  key_last_ff;
   logic [15:0] scale_ff;

   logic csr_write;
   logic [1:0] csr_index;

   logic push;
   kcp_pkg::job_type push_job;
   logic pop;
   logic queue_full;
   logic queue_not_empty;
   kcp_pkg::job_type head_job;

   // register file
   assign csr_pready = 1'b1;
   assign csr_index = csr_paddr[4:3];
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff <= 64'd0;
         key_mid_ff <= 64'd0;
         key_last_ff <= 8'd0;
         scale_ff <= kcp_pkg::SCALE_RESET;
      end else if (csr_write) begin
         case (csr_index)
            kcp_pkg::ADDR_KEY_LOW: key_low_ff <= csr_pwdata;
            kcp_pkg::ADDR_KEY_MID: key_mid_ff <= csr_pwdata;
            kcp_pkg::ADDR_KEY_LAST: key_last_ff <= csr_pwdata[7:0];
            kcp_pkg::ADDR_SCALE: scale_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         kcp_pkg::ADDR_KEY_LOW: csr_prdata = key_low_ff;
         kcp_pkg::ADDR_KEY_MID: csr_prdata = key_mid_ff;
         kcp_pkg::ADDR_KEY_LAST: csr_prdata = {56'd0, key_last_ff};
         kcp_pkg::ADDR_SCALE: csr_prdata = {48'd0, scale_ff};
         default: csr_prdata = 64'd0;
      endcase
   end

   // byte parser: key check, tags, decimal digit accumulation
   kcp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .key_vec    ({key_last_ff, key_mid_ff, key_low_ff}),
      .queue_full (queue_full),
      .push       (push),
      .push_job   (push_job)
   );

   // short job queue between parser and arithmetic
   kcp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .pop       (pop),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .head_job  (head_job)
   );

   // decimal scaling divide, set point multiply, saturation, result register
   kcp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .not_empty  (queue_not_empty),
      .head_job   (head_job),
      .pop        (pop),
      .scale      (scale_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
